FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the stable sorted priority queue
// Request codes, default sizes and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Default sizes
  localparam int unsigned DEF_CAPACITY       = 16;
  localparam int unsigned DEF_VALUE_WIDTH    = 16;
  localparam int unsigned DEF_PRIORITY_WIDTH = 8;

  // Fixed field widths
  localparam int unsigned REQ_W = 2;
  localparam int unsigned OCC_W = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;   // insert new entry into the sorted row
    logic rem;   // pop head, shift row toward head
  } spq_ctl_t;

endpackage : spq_pkg

`default_nettype wire

FILE: design/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: bounded FIFO-stable priority queue
// A row of CAPACITY cells kept sorted by priority; insert, remove most
// urgent and clear, each answered with flags and occupancy.
// ----------------------------------------------------------------------------
// Result: an accepted request's result is registered into the output register.
// Throughput: 1 request per cycle while the result channel is free or draining;
//   every cell compares its priority with the incoming one in parallel and the whole row updates in that same cycle.
// Reset: fill count cleared to zero, output register empty; cell contents are
//   left undefined and are never read before being written.
`default_nettype none

module stable_sorted_priority_queue #(
  parameter int unsigned CAPACITY       = spq_pkg::DEF_CAPACITY,
  parameter int unsigned VALUE_WIDTH    = spq_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH,
  localparam int unsigned IN_W  = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
  localparam int unsigned RES_W = VALUE_WIDTH + PRIORITY_WIDTH + 4 + spq_pkg::OCC_W,
  localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // Request channel
  input  wire                       s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire [IN_W-1:0]            s_axis_tdata,  // item_value, item_priority
  input  wire [spq_pkg::REQ_W-1:0]  s_axis_tuser,  // req_type
  // Result channel
  output logic                      m_axis_tvalid,
  input  wire                       m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata   // out_value, out_priority,
                                                   // out_valid, accepted, now_empty,
                                                   // now_full, occupancy
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                      req_fire;
  logic [REQ_W-1:0]          req_type;
  logic [VALUE_WIDTH-1:0]    item_value;
  logic [PRIORITY_WIDTH-1:0] item_priority;

  logic [CNT_W-1:0] count_q, count_d;
  logic             is_full, is_empty;
  logic             do_ins, do_rem, do_clr;
  spq_ctl_t         ctl;

  logic [VALUE_WIDTH-1:0]    cell_value    [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] cell_priority [CAPACITY];
  logic                      cell_after    [CAPACITY];

  logic                   m_valid_q;
  logic [OUT_W-1:0]       m_data_q, m_data_d;
  logic [RES_W-1:0]       result;
  logic                   res_accepted;

  // Unpack request
  assign req_type      = s_axis_tuser;
  assign item_value    = s_axis_tdata[VALUE_WIDTH-1:0];
  assign item_priority = s_axis_tdata[VALUE_WIDTH+PRIORITY_WIDTH-1:VALUE_WIDTH];

  // Take a request whenever the output register is free or draining
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign req_fire      = s_axis_tvalid && s_axis_tready;

  // Decode request against fill state
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_clr = 1'b0;
    case (req_type)
      REQ_INSERT: do_ins = req_fire && !is_full;
      REQ_REMOVE: do_rem = req_fire && !is_empty;
      REQ_CLEAR:  do_clr = req_fire;
      default:    ;
    endcase
  end

  assign ctl.ins = do_ins;
  assign ctl.rem = do_rem;
  assign res_accepted = do_ins || do_rem || do_clr;

  // Advance fill count
  always_comb begin
    count_d = count_q;
    if (do_clr) begin
      count_d = '0;
    end else if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Sorted cell row, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      l_after;
    logic [VALUE_WIDTH-1:0]    l_value, r_value;
    logic [PRIORITY_WIDTH-1:0] l_priority, r_priority;

    if (i == 0) begin : g_head
      assign l_after    = 1'b1;
      assign l_value    = item_value;
      assign l_priority = item_priority;
    end else begin : g_mid
      assign l_after    = cell_after[i-1];
      assign l_value    = cell_value[i-1];
      assign l_priority = cell_priority[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_value    = cell_value[i];
      assign r_priority = cell_priority[i];
    end else begin : g_body
      assign r_value    = cell_value[i+1];
      assign r_priority = cell_priority[i+1];
    end

    spq_cell #(
      .IDX           (i),
      .CNT_W         (CNT_W),
      .VALUE_WIDTH   (VALUE_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk_i           (clk_i),
      .ctl_i           (ctl),
      .count_i         (count_q),
      .new_value_i     (item_value),
      .new_priority_i  (item_priority),
      .left_after_i    (l_after),
      .left_value_i    (l_value),
      .left_priority_i (l_priority),
      .right_value_i   (r_value),
      .right_priority_i(r_priority),
      .after_o         (cell_after[i]),
      .value_o         (cell_value[i]),
      .priority_o      (cell_priority[i])
    );
  end

  // Build result word
  assign result = {
    OCC_W'(count_d),
    (count_d == CNT_W'(CAPACITY)),
    (count_d == '0),
    res_accepted,
    do_rem,
    (do_rem ? cell_priority[0] : {PRIORITY_WIDTH{1'b0}}),
    (do_rem ? cell_value[0]    : {VALUE_WIDTH{1'b0}})
  };

  assign m_data_d = OUT_W'(result);

  // Hold count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (req_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule : stable_sorted_priority_queue

`default_nettype wire

FILE: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted entry row
// Holds one value and priority, compares against the incoming priority and
// takes its own, the new, the left or the right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
  parameter int unsigned IDX            = 0,
  parameter int unsigned CNT_W          = 5,
  parameter int unsigned VALUE_WIDTH    = 16,
  parameter int unsigned PRIORITY_WIDTH = 8
) (
  input  wire                        clk_i,
  input  wire spq_pkg::spq_ctl_t     ctl_i,
  input  wire [CNT_W-1:0]            count_i,
  input  wire [VALUE_WIDTH-1:0]      new_value_i,
  input  wire [PRIORITY_WIDTH-1:0]   new_priority_i,
  input  wire                        left_after_i,   // left cell keeps its entry
  input  wire [VALUE_WIDTH-1:0]      left_value_i,
  input  wire [PRIORITY_WIDTH-1:0]   left_priority_i,
  input  wire [VALUE_WIDTH-1:0]      right_value_i,
  input  wire [PRIORITY_WIDTH-1:0]   right_priority_i,
  output logic                       after_o,        // new entry goes behind this one
  output logic [VALUE_WIDTH-1:0]     value_o,
  output logic [PRIORITY_WIDTH-1:0]  priority_o
);
  import spq_pkg::*;

  logic                      occupied;
  logic [VALUE_WIDTH-1:0]    value_q, value_d;
  logic [PRIORITY_WIDTH-1:0] priority_q, priority_d;

  // Slot holds a live entry when it lies below the fill count
  assign occupied = (CNT_W'(IDX) < count_i);
  assign after_o  = occupied && (priority_q <= new_priority_i);

  // Pick next entry: keep, take new, shift from left or shift from right
  always_comb begin
    value_d    = value_q;
    priority_d = priority_q;
    if (ctl_i.ins) begin
      if (!after_o) begin
        if (left_after_i) begin
          value_d    = new_value_i;
          priority_d = new_priority_i;
        end else begin
          value_d    = left_value_i;
          priority_d = left_priority_i;
        end
      end
    end else if (ctl_i.rem) begin
      value_d    = right_value_i;
      priority_d = right_priority_i;
    end
  end

  // Hold entry
  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    priority_q <= priority_d;
  end

  assign value_o    = value_q;
  assign priority_o = priority_q;

endmodule : spq_cell

`default_nettype wire

FILE: tb/stable_sorted_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_tb: self-checking bench for the sorted queue
// Drives insert, remove, clear and reserved requests into the request stream
// and checks every response against a behavioral queue tracker. Both stream
// sides idle at random. One long back-pressure stretch fills the block, and
// one pause lets every pending response drain.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_sorted_priority_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP      = spq_pkg::DEF_CAPACITY;
  localparam int unsigned VAL_W    = spq_pkg::DEF_VALUE_WIDTH;
  localparam int unsigned PRIO_W   = spq_pkg::DEF_PRIORITY_WIDTH;
  localparam int unsigned IN_W     = ((VAL_W + PRIO_W + 7) / 8) * 8;
  localparam int unsigned RSP_W    = VAL_W + PRIO_W + 4 + spq_pkg::OCC_W;
  localparam int unsigned OUT_W    = ((RSP_W + 7) / 8) * 8;

  localparam logic [spq_pkg::REQ_W-1:0] REQ_RESERVED = 2'd3;

  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 1225;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 4;
  localparam int STALL_LIMIT    = 2000;

  // Response fields, lowest bit last
  typedef struct packed {
    logic [spq_pkg::OCC_W-1:0] occupancy;
    logic                      now_full;
    logic                      now_empty;
    logic                      accepted;
    logic                      out_valid;
    logic [PRIO_W-1:0]         out_priority;
    logic [VAL_W-1:0]          out_value;
  } queue_rsp_t;

  // Tracks queue contents and the responses still owed by the block
  class queue_tracker;
    logic [VAL_W-1:0]  held_value [CAP];
    logic [PRIO_W-1:0] held_prio  [CAP];
    int unsigned       held_count;
    queue_rsp_t        owed_rsp [$];
    int unsigned       mismatch_count;

    function new();
      held_count     = 0;
      mismatch_count = 0;
    endfunction

    // Apply one accepted request and queue the response it must produce
    function void note_request(logic [spq_pkg::REQ_W-1:0] code, logic [VAL_W-1:0] val,
                               logic [PRIO_W-1:0] prio);
      queue_rsp_t  rsp;
      int unsigned pos;
      int unsigned i;
      rsp = '0;
      case (code)
        spq_pkg::REQ_INSERT: begin
          if (held_count < CAP) begin
            // place after every entry of equal or more urgent priority
            pos = 0;
            while (pos < held_count && held_prio[pos] <= prio) pos++;
            for (i = held_count; i > pos; i--) begin
              held_value[i] = held_value[i-1];
              held_prio[i]  = held_prio[i-1];
            end
            held_value[pos] = val;
            held_prio[pos]  = prio;
            held_count++;
            rsp.accepted = 1'b1;
          end
        end
        spq_pkg::REQ_REMOVE: begin
          if (held_count > 0) begin
            rsp.out_value    = held_value[0];
            rsp.out_priority = held_prio[0];
            for (i = 1; i < held_count; i++) begin
              held_value[i-1] = held_value[i];
              held_prio[i-1]  = held_prio[i];
            end
            held_count--;
            rsp.out_valid = 1'b1;
            rsp.accepted  = 1'b1;
          end
        end
        spq_pkg::REQ_CLEAR: begin
          held_count   = 0;
          rsp.accepted = 1'b1;
        end
        default: ;
      endcase
      rsp.now_empty = (held_count == 0);
      rsp.now_full  = (held_count >= CAP);
      rsp.occupancy = held_count[spq_pkg::OCC_W-1:0];
      owed_rsp.push_back(rsp);
    endfunction

    function void flag_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    // Compare one delivered response with the oldest owed one
    function void check_response(logic [OUT_W-1:0] data);
      queue_rsp_t got;
      queue_rsp_t want;
      got = queue_rsp_t'(data[RSP_W-1:0]);
      if (owed_rsp.size() == 0) begin
        $display("%0t: response expected none actual %0h", $time, data);
        mismatch_count++;
      end else begin
        want = owed_rsp.pop_front();
        flag_field("out_value",    want.out_value,    got.out_value);
        flag_field("out_priority", want.out_priority, got.out_priority);
        flag_field("out_valid",    want.out_valid,    got.out_valid);
        flag_field("accepted",     want.accepted,     got.accepted);
        flag_field("now_empty",    want.now_empty,    got.now_empty);
        flag_field("now_full",     want.now_full,     got.now_full);
        flag_field("occupancy",    want.occupancy,    got.occupancy);
      end
    endfunction
  endclass

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_W-1:0]           s_axis_tdata  = '0;  // item_value, item_priority
  logic [spq_pkg::REQ_W-1:0] s_axis_tuser  = '0;  // req_type
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_W-1:0]          m_axis_tdata;        // out_value, out_priority, out_valid,
                                                  // accepted, now_empty, now_full,
                                                  // occupancy

  bit          idling_on    = 1'b1;
  bit          hold_pending = 1'b0;
  int unsigned quiet_cycles = 0;

  queue_tracker tracker = new();

  stable_sorted_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Record accepted requests and responses; stop the run if traffic dies
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_request(s_axis_tuser, s_axis_tdata[VAL_W-1:0],
                             s_axis_tdata[VAL_W+PRIO_W-1:VAL_W]);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_response(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Response side: random back-pressure, plus one long hold-off on demand
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (idling_on) begin
        m_axis_tready <= ($urandom_range(0, 99) >= 20);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until the block takes it
  task automatic send_request(logic [spq_pkg::REQ_W-1:0] code, logic [VAL_W-1:0] val,
                              logic [PRIO_W-1:0] prio);
    @(negedge clk_i);
    while (idling_on && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= IN_W'({prio, val});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Pick a request kind biased toward filling or toward draining
  task automatic send_random(bit fill_bias);
    int unsigned               roll;
    logic [spq_pkg::REQ_W-1:0] code;
    logic [VAL_W-1:0]          val;
    logic [PRIO_W-1:0]         prio;
    roll = $urandom_range(0, 99);
    if (roll < (fill_bias ? 68 : 30))
      code = spq_pkg::REQ_INSERT;
    else if (roll < 97)
      code = spq_pkg::REQ_REMOVE;
    else if (roll < 99)
      code = spq_pkg::REQ_CLEAR;
    else
      code = REQ_RESERVED;
    val = VAL_W'($urandom());
    // small priorities give many ties to exercise FIFO order
    prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 7)) : PRIO_W'($urandom());
    send_request(code, val, prio);
  endtask

  // Drop valid and wait until every owed response has come back
  task automatic drain_responses();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.owed_rsp.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic [PRIO_W-1:0] fill_prio [16];
    logic [VAL_W-1:0]  val;
    int                i;
    fill_prio = '{8'd5, 8'd5, 8'd0, 8'hFF, 8'd3, 8'd5, 8'd0, 8'hFF,
                  8'd7, 8'd3, 8'd5, 8'd128, 8'd1, 8'd0, 8'hFF, 8'd5};

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue: refused remove, reserved code, clear
    send_request(spq_pkg::REQ_REMOVE, 16'hFFFF, 8'hFF);
    send_request(REQ_RESERVED, 16'h0000, 8'h00);
    send_request(spq_pkg::REQ_CLEAR, 16'h0000, 8'h00);

    // Fill to capacity with ties and extreme priorities
    for (i = 0; i < CAP; i++) begin
      val = (i == 0) ? '0 : (i == 1) ? '1 : VAL_W'($urandom());
      send_request(spq_pkg::REQ_INSERT, val, fill_prio[i]);
    end

    // Full queue: refused insert, reserved code, then two pops, clear and pop empty
    send_request(spq_pkg::REQ_INSERT, 16'h5A5A, 8'h00);
    send_request(REQ_RESERVED, 16'hFFFF, 8'hFF);
    send_request(spq_pkg::REQ_REMOVE, 16'h0000, 8'h00);
    send_request(spq_pkg::REQ_REMOVE, 16'h0000, 8'h00);
    send_request(spq_pkg::REQ_CLEAR, 16'hFFFF, 8'hFF);
    send_request(spq_pkg::REQ_REMOVE, 16'h0000, 8'h00);

    // Random traffic in alternating fill and drain phases
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      idling_on = !(i >= 500 && i < 700);
      if (i == 200) hold_pending = 1'b1;
      if (i == 900) drain_responses();
      send_random(((i / 50) % 2) == 0);
    end

    drain_responses();
    if (tracker.mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule : stable_sorted_priority_queue_tb

`default_nettype wire

FILE: sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/stable_sorted_priority_queue.sv
tb/stable_sorted_priority_queue_tb.sv
